/* rtl/itf_pkg.sv */
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, constants and helper functions of the integer text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

   localparam int REQ_W     = 96;
   localparam int RSP_W     = 16;
   localparam int BASE_W    = 5;
   localparam int FLD_W     = 6;
   localparam int ROOM_W    = 7;
   localparam int CNT_W     = 7;
   localparam int POS_W     = 6;
   localparam int CHUNK     = 8;
   localparam int OUT_LIMIT = 63;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UPX   = 8'h58;
   localparam logic [7:0] CH_LOWX  = 8'h78;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_LOWA  = 8'h61;

   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_SPACE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_TOTAL,
      ST_GROUP,
      ST_FIELD,
      ST_PLAN,
      ST_LEAD,
      ST_SIGN,
      ST_PFX0,
      ST_PFX1,
      ST_ZPAD,
      ST_DIGIT,
      ST_TRAIL
   } state_type;

   typedef enum logic [2:0] {
      KIND_SPACE_PAD,
      KIND_SIGN,
      KIND_PFX_ZERO,
      KIND_PFX_MARK,
      KIND_ZERO_PAD,
      KIND_DIGIT
   } kind_type;

   typedef struct packed {
      logic     load;
      logic     div_step;
      logic     total;
      logic     group;
      logic     field;
      logic     emit;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic pad_nz;
      logic pad_one;
      logic dig_last;
      logic is_last;
      logic out_ready;
      logic has_sign;
      logic hex_prefix;
      logic lead_pad;
      logic zero_pad;
   } status_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'b0, d};
      end else begin
         c = (upper ? CH_UPA : CH_LOWA) + {4'b0, d} - 8'd10;
      end
      return c;
   endfunction

   // Exact for every 7-bit value: multiply by 171/512.
   function automatic logic [CNT_W-1:0] div3(input logic [CNT_W-1:0] x);
      logic [14:0] p;
      p = 15'(x) * 15'd171;
      return CNT_W'(p >> 9);
   endfunction

endpackage

/* rtl/itf_ctrl.sv */
// ----------------------------------------------------------------------------
// itf_ctrl
// Sequencer: division, field sizing, then one field segment after another.
// ----------------------------------------------------------------------------
module itf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  itf_pkg::status_type stat,
   output itf_pkg::cmd_type    cmd
);

   itf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == itf_pkg::ST_IDLE);

   always_comb begin
      itf_pkg::state_type after_pfx;
      itf_pkg::state_type after_sign;
      itf_pkg::state_type after_lead;
      itf_pkg::state_type first_seg;

      after_pfx  = (stat.zero_pad && stat.pad_nz) ? itf_pkg::ST_ZPAD : itf_pkg::ST_DIGIT;
      after_sign = stat.hex_prefix ? itf_pkg::ST_PFX0 : after_pfx;
      after_lead = stat.has_sign ? itf_pkg::ST_SIGN : after_sign;
      first_seg  = (stat.lead_pad && stat.pad_nz) ? itf_pkg::ST_LEAD : after_lead;

      state_in = state_ff;
      cmd      = '0;

      unique case (state_ff)
         itf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = itf_pkg::ST_DIV;
            end
         end
         itf_pkg::ST_DIV: begin
            if (stat.div_done) begin
               state_in = itf_pkg::ST_TOTAL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         itf_pkg::ST_TOTAL: begin
            cmd.total = 1'b1;
            state_in  = itf_pkg::ST_GROUP;
         end
         itf_pkg::ST_GROUP: begin
            cmd.group = 1'b1;
            state_in  = itf_pkg::ST_FIELD;
         end
         itf_pkg::ST_FIELD: begin
            cmd.field = 1'b1;
            state_in  = itf_pkg::ST_PLAN;
         end
         itf_pkg::ST_PLAN: begin
            state_in = first_seg;
         end
         itf_pkg::ST_LEAD: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               cmd.kind = itf_pkg::KIND_SPACE_PAD;
               if (stat.pad_one) state_in = after_lead;
            end
         end
         itf_pkg::ST_SIGN: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               cmd.kind = itf_pkg::KIND_SIGN;
               state_in = after_sign;
            end
         end
         itf_pkg::ST_PFX0: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               cmd.kind = itf_pkg::KIND_PFX_ZERO;
               state_in = itf_pkg::ST_PFX1;
            end
         end
         itf_pkg::ST_PFX1: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               cmd.kind = itf_pkg::KIND_PFX_MARK;
               state_in = after_pfx;
            end
         end
         itf_pkg::ST_ZPAD: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               cmd.kind = itf_pkg::KIND_ZERO_PAD;
               if (stat.pad_one) state_in = itf_pkg::ST_DIGIT;
            end
         end
         itf_pkg::ST_DIGIT: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               cmd.kind = itf_pkg::KIND_DIGIT;
               if (stat.dig_last) state_in = itf_pkg::ST_TRAIL;
            end
         end
         itf_pkg::ST_TRAIL: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               cmd.kind = itf_pkg::KIND_SPACE_PAD;
            end
         end
         default: begin
            state_in = itf_pkg::ST_IDLE;
         end
      endcase

      // The final word of a field, natural or truncated, ends the item.
      if (cmd.emit && stat.is_last) begin
         state_in = itf_pkg::ST_IDLE;
      end
   end

endmodule

/* rtl/itf_dp.sv */
// ----------------------------------------------------------------------------
// itf_dp
// Datapath: radix divider, digit stack, field sizing and the output register.
// ----------------------------------------------------------------------------
module itf_dp #(
   parameter int VALUE_BITS    = 64,
   parameter int MAX_WIDTH     = 63,
   parameter int MAX_PRECISION = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  itf_pkg::cmd_type             cmd,
   output itf_pkg::status_type          stat,
   input  logic [63:0]                  req_value,
   input  logic [itf_pkg::BASE_W-1:0]   req_base,
   input  logic [itf_pkg::FLD_W-1:0]    req_width,
   input  logic [itf_pkg::FLD_W-1:0]    req_precision,
   input  logic [itf_pkg::ROOM_W-1:0]   req_room,
   input  logic [1:0]                   req_sign_mode,
   input  logic                         req_is_signed,
   input  logic                         req_upper_case,
   input  logic                         req_left_justify,
   input  logic                         req_zero_pad,
   input  logic                         req_alt_form,
   input  logic                         req_group_digits,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [7:0]                   rsp_character,
   output logic [itf_pkg::POS_W-1:0]    rsp_position,
   output logic                         rsp_stored,
   output logic                         rsp_last
);

   localparam int DIV_W   = ((VALUE_BITS + itf_pkg::CHUNK - 1) / itf_pkg::CHUNK) * itf_pkg::CHUNK;
   localparam int DIV_CYC = DIV_W / itf_pkg::CHUNK;
   localparam int DCNT_W  = $clog2(DIV_CYC + 1);
   localparam int DEPTH   = VALUE_BITS;
   localparam int CW      = itf_pkg::CNT_W;
   localparam int PW      = itf_pkg::POS_W;

   logic [DIV_W-1:0]              q_ff, q_in;
   logic [3:0]                    rem_ff, rem_in;
   logic [DCNT_W-1:0]             div_cnt_ff, div_cnt_in;
   logic [CW-1:0]                 nd_ff, nd_in;
   logic [3:0]                    stack_ff [DEPTH];
   logic [3:0]                    stack_in [DEPTH];
   logic [itf_pkg::BASE_W-1:0]    base_ff, base_in;
   logic [itf_pkg::FLD_W-1:0]     width_ff, width_in;
   logic [itf_pkg::FLD_W-1:0]     prec_ff, prec_in;
   logic [itf_pkg::ROOM_W-1:0]    room_ff, room_in;
   logic [1:0]                    sign_mode_ff, sign_mode_in;
   logic                          minus_ff, minus_in;
   logic                          upper_ff, upper_in;
   logic                          left_ff, left_in;
   logic                          zpad_ff, zpad_in;
   logic                          alt_ff, alt_in;
   logic                          group_ff, group_in;
   logic [CW-1:0]                 dig_cnt_ff, dig_cnt_in;
   logic [CW-1:0]                 seps_ff, seps_in;
   logic [1:0]                    mod_ff, mod_in;
   logic                          first_ff, first_in;
   logic                          sep_done_ff, sep_done_in;
   logic [PW-1:0]                 pad_ff, pad_in;
   logic [PW-1:0]                 len_ff, len_in;
   logic [PW-1:0]                 pos_ff, pos_in;
   logic [7:0]                    out_char_ff, out_char_in;
   logic [PW-1:0]                 out_pos_ff, out_pos_in;
   logic                          out_stored_ff, out_stored_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_valid_ff, out_valid_in;

   logic                          sixteen;
   logic                          hex_prefix;
   logic                          has_sign;
   logic                          sep_due;
   logic                          is_last;

   assign sixteen    = (base_ff == itf_pkg::BASE_W'(16));
   assign hex_prefix = alt_ff && sixteen;
   assign has_sign   = minus_ff || (sign_mode_ff != itf_pkg::SIGN_NONE);
   assign sep_due    = group_ff && !first_ff && (mod_ff == 2'd0) && !sep_done_ff;
   assign is_last    = (pos_ff == len_ff - PW'(1));

   assign stat.div_done   = (q_ff == '0) && (div_cnt_ff == '0);
   assign stat.pad_nz     = (pad_ff != '0);
   assign stat.pad_one    = (pad_ff == PW'(1));
   assign stat.dig_last   = (dig_cnt_ff == CW'(1)) && !sep_due;
   assign stat.is_last    = is_last;
   assign stat.out_ready  = !out_valid_ff || rsp_tready;
   assign stat.has_sign   = has_sign;
   assign stat.hex_prefix = hex_prefix;
   assign stat.lead_pad   = !left_ff && !zpad_ff;
   assign stat.zero_pad   = zpad_ff;

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_position  = out_pos_ff;
   assign rsp_stored    = out_stored_ff;
   assign rsp_last      = out_last_ff;

   always_comb begin
      logic [VALUE_BITS-1:0]  v;
      logic                   neg;
      logic [VALUE_BITS-1:0]  mag;
      logic [3:0]             r;
      logic [4:0]             t;
      logic [itf_pkg::CHUNK-1:0] qb;
      logic [CW-1:0]          nd_p1;
      logic [CW-1:0]          eff_prec;
      logic [CW-1:0]          tot;
      logic [CW-1:0]          gq;
      logic [1:0]             gm;
      logic [CW-1:0]          nchars;
      logic [CW-1:0]          wide;
      logic [CW-1:0]          full;
      logic [7:0]             ch;
      logic [7:0]             sign_ch;
      logic                   pad_dec;

      q_in          = q_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      nd_in         = nd_ff;
      stack_in      = stack_ff;
      base_in       = base_ff;
      width_in      = width_ff;
      prec_in       = prec_ff;
      room_in       = room_ff;
      sign_mode_in  = sign_mode_ff;
      minus_in      = minus_ff;
      upper_in      = upper_ff;
      left_in       = left_ff;
      zpad_in       = zpad_ff;
      alt_in        = alt_ff;
      group_in      = group_ff;
      dig_cnt_in    = dig_cnt_ff;
      seps_in       = seps_ff;
      mod_in        = mod_ff;
      first_in      = first_ff;
      sep_done_in   = sep_done_ff;
      pad_in        = pad_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      out_char_in   = out_char_ff;
      out_pos_in    = out_pos_ff;
      out_stored_in = out_stored_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff;

      v   = req_value[VALUE_BITS-1:0];
      neg = req_is_signed && v[VALUE_BITS-1];
      mag = neg ? (~v + VALUE_BITS'(1)) : v;

      r  = rem_ff;
      qb = '0;
      for (int s = 0; s < itf_pkg::CHUNK; s++) begin
         t = {r, q_ff[DIV_W-1-s]};
         if (t >= base_ff) begin
            r = 4'(t - base_ff);
            qb[itf_pkg::CHUNK-1-s] = 1'b1;
         end else begin
            r = t[3:0];
         end
      end

      nd_p1    = nd_ff + CW'(1);
      eff_prec = CW'(prec_ff);
      if (alt_ff && (base_ff == itf_pkg::BASE_W'(8)) && (eff_prec < nd_p1)) begin
         eff_prec = nd_p1;
      end
      tot = (nd_ff > eff_prec) ? nd_ff : eff_prec;
      if (tot == '0) tot = CW'(1);

      if (sixteen) begin
         gq = dig_cnt_ff >> 2;
         gm = dig_cnt_ff[1:0];
      end else begin
         gq = itf_pkg::div3(dig_cnt_ff);
         gm = 2'(dig_cnt_ff - gq - (gq << 1));
      end

      nchars = dig_cnt_ff + seps_ff + CW'(has_sign) + (hex_prefix ? CW'(2) : CW'(0));
      wide   = CW'(width_ff);
      full   = (wide > nchars) ? wide : nchars;

      if (minus_ff) begin
         sign_ch = itf_pkg::CH_MINUS;
      end else if (sign_mode_ff == itf_pkg::SIGN_SPACE) begin
         sign_ch = itf_pkg::CH_SPACE;
      end else begin
         sign_ch = itf_pkg::CH_PLUS;
      end

      pad_dec = 1'b0;
      unique case (cmd.kind)
         itf_pkg::KIND_SPACE_PAD: begin
            ch      = itf_pkg::CH_SPACE;
            pad_dec = 1'b1;
         end
         itf_pkg::KIND_SIGN: begin
            ch = sign_ch;
         end
         itf_pkg::KIND_PFX_ZERO: begin
            ch = itf_pkg::CH_ZERO;
         end
         itf_pkg::KIND_PFX_MARK: begin
            ch = upper_ff ? itf_pkg::CH_UPX : itf_pkg::CH_LOWX;
         end
         itf_pkg::KIND_ZERO_PAD: begin
            ch      = itf_pkg::CH_ZERO;
            pad_dec = 1'b1;
         end
         itf_pkg::KIND_DIGIT: begin
            if (sep_due) begin
               ch = itf_pkg::CH_UNDER;
            end else if (dig_cnt_ff > nd_ff) begin
               ch = itf_pkg::CH_ZERO;
            end else begin
               ch = itf_pkg::digit_char(stack_ff[0], upper_ff);
            end
         end
         default: begin
            ch = itf_pkg::CH_SPACE;
         end
      endcase

      if (cmd.load) begin
         q_in         = DIV_W'(mag);
         rem_in       = '0;
         div_cnt_in   = '0;
         nd_in        = '0;
         minus_in     = neg;
         if (req_base < itf_pkg::BASE_W'(2)) begin
            base_in = itf_pkg::BASE_W'(2);
         end else if (req_base > itf_pkg::BASE_W'(16)) begin
            base_in = itf_pkg::BASE_W'(16);
         end else begin
            base_in = req_base;
         end
         width_in     = (req_width > itf_pkg::FLD_W'(MAX_WIDTH)) ?
                        itf_pkg::FLD_W'(MAX_WIDTH) : req_width;
         prec_in      = (req_precision > itf_pkg::FLD_W'(MAX_PRECISION)) ?
                        itf_pkg::FLD_W'(MAX_PRECISION) : req_precision;
         room_in      = req_room;
         sign_mode_in = req_sign_mode;
         upper_in     = req_upper_case;
         left_in      = req_left_justify;
         zpad_in      = req_zero_pad && !req_left_justify;
         alt_in       = req_alt_form;
         group_in     = req_group_digits;
         pos_in       = '0;
      end

      if (cmd.div_step) begin
         q_in = (q_ff << itf_pkg::CHUNK) | DIV_W'(qb);
         if (div_cnt_ff == DCNT_W'(DIV_CYC - 1)) begin
            div_cnt_in  = '0;
            rem_in      = '0;
            nd_in       = nd_ff + CW'(1);
            stack_in[0] = r;
            for (int k = 1; k < DEPTH; k++) begin
               stack_in[k] = stack_ff[k-1];
            end
         end else begin
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            rem_in     = r;
         end
      end

      if (cmd.total) begin
         dig_cnt_in  = tot;
         first_in    = 1'b1;
         sep_done_in = 1'b0;
      end

      if (cmd.group) begin
         mod_in = gm;
         if (!group_ff) begin
            seps_in = '0;
         end else if (gm == 2'd0) begin
            seps_in = gq - CW'(1);
         end else begin
            seps_in = gq;
         end
      end

      if (cmd.field) begin
         pad_in = (wide > nchars) ? PW'(wide - nchars) : '0;
         len_in = (full > CW'(itf_pkg::OUT_LIMIT)) ? PW'(itf_pkg::OUT_LIMIT) : PW'(full);
      end

      if (cmd.emit) begin
         out_char_in   = ch;
         out_pos_in    = pos_ff;
         out_stored_in = ({1'b0, pos_ff} < room_ff);
         out_last_in   = is_last;
         out_valid_in  = 1'b1;
         pos_in        = pos_ff + PW'(1);
         if (pad_dec) begin
            pad_in = pad_ff - PW'(1);
         end
         if (cmd.kind == itf_pkg::KIND_DIGIT) begin
            if (sep_due) begin
               sep_done_in = 1'b1;
            end else begin
               dig_cnt_in  = dig_cnt_ff - CW'(1);
               first_in    = 1'b0;
               sep_done_in = 1'b0;
               mod_in      = (mod_ff == 2'd0) ? (sixteen ? 2'd3 : 2'd2) : mod_ff - 2'd1;
               if (dig_cnt_ff <= nd_ff) begin
                  for (int k = 0; k < DEPTH - 1; k++) begin
                     stack_in[k] = stack_ff[k+1];
                  end
                  stack_in[DEPTH-1] = '0;
               end
            end
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      nd_ff         <= nd_in;
      stack_ff      <= stack_in;
      base_ff       <= base_in;
      width_ff      <= width_in;
      prec_ff       <= prec_in;
      room_ff       <= room_in;
      sign_mode_ff  <= sign_mode_in;
      minus_ff      <= minus_in;
      upper_ff      <= upper_in;
      left_ff       <= left_in;
      zpad_ff       <= zpad_in;
      alt_ff        <= alt_in;
      group_ff      <= group_in;
      dig_cnt_ff    <= dig_cnt_in;
      seps_ff       <= seps_in;
      mod_ff        <= mod_in;
      first_ff      <= first_in;
      sep_done_ff   <= sep_done_in;
      pad_ff        <= pad_in;
      len_ff        <= len_in;
      pos_ff        <= pos_in;
      out_char_ff   <= out_char_in;
      out_pos_ff    <= out_pos_in;
      out_stored_ff <= out_stored_in;
      out_last_ff   <= out_last_in;
   end

endmodule

/* rtl/integer_text_formatter_top.sv */
// ----------------------------------------------------------------------------
// integer_text_formatter_top
// Formats one integer as the characters of a printf-style integer field.
// ----------------------------------------------------------------------------
// One request word is taken at a time. The digits come from a radix divider
// that retires eight quotient bits per cycle and passes the whole quotient
// through once for each digit. Field sizing follows in the total, group,
// field and plan states, then one character word per cycle while the consumer
// keeps up, at most 63 words. A new request is taken as soon as the final
// character of the previous one sits in the output register.
module integer_text_formatter_top #(
   parameter int VALUE_BITS    = 64,
   parameter int MAX_WIDTH     = 63,
   parameter int MAX_PRECISION = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // value, base, width, precision, room, sign_mode, upper_case,
   // left_justify, zero_pad, alt_form, group_digits, zero fill
   input  logic [itf_pkg::REQ_W-1:0] req_tdata,
   // is_signed
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // character, position, zero fill
   output logic [itf_pkg::RSP_W-1:0] rsp_tdata,
   // stored
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   itf_pkg::cmd_type                cmd;
   itf_pkg::status_type             stat;
   logic [7:0]                      rsp_character;
   logic [itf_pkg::POS_W-1:0]       rsp_position;

   itf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   itf_dp #(
      .VALUE_BITS    (VALUE_BITS),
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_PRECISION (MAX_PRECISION)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_value        (req_tdata[63:0]),
      .req_base         (req_tdata[68:64]),
      .req_width        (req_tdata[74:69]),
      .req_precision    (req_tdata[80:75]),
      .req_room         (req_tdata[87:81]),
      .req_sign_mode    (req_tdata[89:88]),
      .req_is_signed    (req_tuser),
      .req_upper_case   (req_tdata[90]),
      .req_left_justify (req_tdata[91]),
      .req_zero_pad     (req_tdata[92]),
      .req_alt_form     (req_tdata[93]),
      .req_group_digits (req_tdata[94]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_character    (rsp_character),
      .rsp_position     (rsp_position),
      .rsp_stored       (rsp_tuser),
      .rsp_last         (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_position, rsp_character};

endmodule

/* rtl/itf_chk.sv */
// ----------------------------------------------------------------------------
// itf_chk
// Port-level checks of the integer text formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itf_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [itf_pkg::REQ_W-1:0] req_tdata,
   input logic                      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [itf_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      rsp_tlast
);

   logic                      req_acc;
   logic                      rsp_acc;
   logic [itf_pkg::POS_W-1:0] pos_exp_ff, pos_exp_in;
   logic [1:0]                open_ff, open_in;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pos_exp_in = pos_exp_ff;
      if (rsp_acc) begin
         pos_exp_in = rsp_tlast ? '0 : pos_exp_ff + itf_pkg::POS_W'(1);
      end
      open_in = open_ff + 2'(req_acc) - 2'(rsp_acc && rsp_tlast);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_exp_ff <= '0;
         open_ff    <= '0;
      end else begin
         pos_exp_ff <= pos_exp_in;
         open_ff    <= open_in;
      end
   end

   // A stalled word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request taken while the previous one is still being formatted");

   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:8] == pos_exp_ff)
      else $error("character position out of sequence");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != 2'd0)
      else $error("rsp word with no request outstanding");

endmodule

bind integer_text_formatter_top itf_chk u_itf_chk (.*);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer text formatter.
// ----------------------------------------------------------------------------
// A table of hand-picked numbers runs first: the extremes of each field, every
// flag, the sign modes, the clamped bases and sizes, and fields that run past
// the character limit. Random numbers follow. The expected character words of
// an accepted request come from its row's text or, if empty, a local field
// builder; every output character word is checked against the oldest one.
// Both sides stall in random bursts, which stop for the last part of the run.
module tb_top;

   localparam int MAX_WIDTH   = 63;
   localparam int MAX_PREC    = 40;
   localparam int RANDOM_NUMS = 420;
   localparam int QUIET_TAIL  = 60;
   localparam int CYCLE_LIMIT = 3_000_000;

   localparam logic [1:0] SIGN_PLUS      = 2'd1;
   localparam logic [1:0] SIGN_PLUS_ALSO = 2'd3;

   localparam logic [5:0] F_SIGNED = 6'b100000;
   localparam logic [5:0] F_UPPER  = 6'b010000;
   localparam logic [5:0] F_LEFT   = 6'b001000;
   localparam logic [5:0] F_ZPAD   = 6'b000100;
   localparam logic [5:0] F_ALT    = 6'b000010;
   localparam logic [5:0] F_GROUP  = 6'b000001;

   typedef struct packed {
      logic [63:0] value;
      logic [4:0]  base;
      logic [5:0]  width;
      logic [5:0]  precision;
      logic [6:0]  room;
      logic [1:0]  sign_mode;
      logic        is_signed;
      logic        upper_case;
      logic        left_justify;
      logic        zero_pad;
      logic        alt_form;
      logic        group_digits;
   } number_req;

   typedef struct packed {
      logic [7:0] character;
      logic [5:0] position;
      logic       stored;
      logic       last;
   } char_word;

   typedef struct {
      number_req num;
      string     text;
   } number_row;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [itf_pkg::REQ_W-1:0] req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [itf_pkg::RSP_W-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;

   char_word  pending_chars [$];
   number_row number_table [$];
   int        mismatches;
   int        cycle_count;
   bit        bursts_on;

   integer_text_formatter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void queue_chars(input byte chars [$], input logic [6:0] room);
      char_word w;
      int       n;
      n = (chars.size() > itf_pkg::OUT_LIMIT) ? itf_pkg::OUT_LIMIT : chars.size();
      for (int k = 0; k < n; k++) begin
         w.character = chars[k];
         w.position  = 6'(k);
         w.stored    = (k < int'(room));
         w.last      = (k == n - 1);
         pending_chars.push_back(w);
      end
   endfunction

   function automatic void predict_field(input number_req r);
      logic [63:0] mag, rest, radix;
      logic [3:0]  digs [0:71];
      byte         chars [$];
      string       set;
      int          fw, pr, nd, total, grp, nchars;
      logic        neg, pad_zero, has_sign, hex_pfx;
      radix = (r.base < 5'd2) ? 64'd2 : (r.base > 5'd16) ? 64'd16 : 64'(r.base);
      fw = (r.width > MAX_WIDTH) ? MAX_WIDTH : int'(r.width);
      pr = (r.precision > MAX_PREC) ? MAX_PREC : int'(r.precision);
      pad_zero = r.zero_pad && !r.left_justify;
      neg = r.is_signed && r.value[63];
      mag = neg ? 64'd0 - r.value : r.value;
      set = r.upper_case ? "0123456789ABCDEF" : "0123456789abcdef";
      rest = mag;
      nd = 0;
      while (rest != 64'd0) begin
         digs[nd] = 4'(rest % radix);
         rest = rest / radix;
         nd++;
      end
      // Octal alternate form always shows a leading zero digit.
      if (r.alt_form && radix == 64'd8 && pr < nd + 1) pr = nd + 1;
      total = (nd < pr) ? pr : ((nd == 0) ? 1 : nd);
      for (int i = nd; i < total; i++) digs[i] = 4'd0;
      grp = !r.group_digits ? total : ((radix == 64'd16) ? 4 : 3);
      has_sign = neg || (r.sign_mode != itf_pkg::SIGN_NONE);
      hex_pfx = r.alt_form && radix == 64'd16;
      nchars = total + (total - 1) / grp + (has_sign ? 1 : 0) + (hex_pfx ? 2 : 0);
      if (!r.left_justify && !pad_zero) begin
         for (int k = nchars; k < fw; k++) chars.push_back(itf_pkg::CH_SPACE);
      end
      if (neg) begin
         chars.push_back(itf_pkg::CH_MINUS);
      end else if (r.sign_mode == itf_pkg::SIGN_SPACE) begin
         chars.push_back(itf_pkg::CH_SPACE);
      end else if (r.sign_mode != itf_pkg::SIGN_NONE) begin
         chars.push_back(itf_pkg::CH_PLUS);
      end
      if (hex_pfx) begin
         chars.push_back(itf_pkg::CH_ZERO);
         chars.push_back(r.upper_case ? itf_pkg::CH_UPX : itf_pkg::CH_LOWX);
      end
      if (pad_zero) begin
         for (int k = nchars; k < fw; k++) chars.push_back(itf_pkg::CH_ZERO);
      end
      for (int i = total - 1; i >= 0; i--) begin
         if (r.group_digits && i != total - 1 && (i + 1) % grp == 0) begin
            chars.push_back(itf_pkg::CH_UNDER);
         end
         chars.push_back(set[digs[i]]);
      end
      if (r.left_justify) begin
         for (int k = nchars; k < fw; k++) chars.push_back(itf_pkg::CH_SPACE);
      end
      queue_chars(chars, r.room);
   endfunction

   function automatic void add_row(input logic [63:0] value, input logic [4:0] base,
                                   input logic [5:0] width, input logic [5:0] precision,
                                   input logic [6:0] room, input logic [1:0] sign_mode,
                                   input logic [5:0] flags, input string text);
      number_row row;
      row.num.value        = value;
      row.num.base         = base;
      row.num.width        = width;
      row.num.precision    = precision;
      row.num.room         = room;
      row.num.sign_mode    = sign_mode;
      {row.num.is_signed, row.num.upper_case, row.num.left_justify,
       row.num.zero_pad, row.num.alt_form, row.num.group_digits} = flags;
      row.text = text;
      number_table.push_back(row);
   endfunction

   function automatic number_req random_number();
      number_req r;
      case ($urandom_range(0, 5))
         0: r.value = 64'($urandom_range(0, 1000));
         1: r.value = {$urandom, $urandom};
         2: r.value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         3: r.value = 64'd0 - 64'($urandom_range(1, 1000));
         4: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: begin
            case ($urandom_range(0, 2))
               0: r.value = '1;
               1: r.value = 64'h8000_0000_0000_0000;
               default: r.value = '0;
            endcase
         end
      endcase
      case ($urandom_range(0, 4))
         0: r.base = 5'($urandom_range(0, 31));
         1: r.base = 5'd8;
         2: r.base = 5'd16;
         3: r.base = 5'd10;
         default: r.base = 5'($urandom_range(2, 16));
      endcase
      r.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 24));
      r.precision = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 12));
      r.room = 7'($urandom_range(0, 127));
      r.sign_mode = 2'($urandom_range(0, 3));
      {r.is_signed, r.upper_case, r.left_justify, r.zero_pad, r.alt_form,
       r.group_digits} = 6'($urandom);
      return r;
   endfunction

   task automatic send_number(input number_row row);
      byte chars [$];
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, row.num.group_digits, row.num.alt_form, row.num.zero_pad,
                     row.num.left_justify, row.num.upper_case, row.num.sign_mode,
                     row.num.room, row.num.precision, row.num.width, row.num.base,
                     row.num.value};
      req_tuser  <= row.num.is_signed;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (row.text.len() != 0) begin
         for (int k = 0; k < row.text.len(); k++) chars.push_back(row.text[k]);
         queue_chars(chars, row.num.room);
      end else begin
         predict_field(row.num);
      end
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   initial begin
      int stall_left;
      char_word want;
      char_word got;
      stall_left = 0;
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.character = rsp_tdata[7:0];
            got.position  = rsp_tdata[13:8];
            got.stored    = rsp_tuser;
            got.last      = rsp_tlast;
            if (pending_chars.size() == 0) begin
               $error("unexpected character word %0h at position %0d",
                      got.character, got.position);
               mismatches++;
            end else begin
               want = pending_chars.pop_front();
               if (got.character !== want.character) begin
                  $error("character: expected %0h, actual %0h", want.character, got.character);
                  mismatches++;
               end
               if (got.position !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position, got.position);
                  mismatches++;
               end
               if (got.stored !== want.stored) begin
                  $error("stored: expected %0b, actual %0b", want.stored, got.stored);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, got.last);
                  mismatches++;
               end
            end
         end
         if (stall_left == 0 && bursts_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      number_row row;
      int        total_nums;
      mismatches = 0;
      bursts_on  = 1'b1;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;

      add_row(64'd0, 5'd10, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, 6'b0, "0");
      add_row('1, 5'd16, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_UPPER,
              "FFFFFFFFFFFFFFFF");
      add_row('1, 5'd2, 6'd0, 6'd0, 7'd127, itf_pkg::SIGN_NONE, F_GROUP, "");
      add_row(64'h8000_0000_0000_0000, 5'd10, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE,
              F_SIGNED, "-9223372036854775808");
      add_row('1, 5'd10, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_SIGNED, "-1");
      add_row(64'd255, 5'd16, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_ALT, "0xff");
      add_row(64'd255, 5'd16, 6'd8, 6'd0, 7'd64, itf_pkg::SIGN_NONE,
              F_ALT | F_ZPAD | F_UPPER, "0X0000FF");
      add_row(64'd8, 5'd8, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_ALT, "010");
      add_row(64'd0, 5'd8, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_ALT, "");
      add_row(64'd42, 5'd10, 6'd6, 6'd0, 7'd64, itf_pkg::SIGN_NONE, 6'b0, "    42");
      add_row(64'd42, 5'd10, 6'd6, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_LEFT | F_ZPAD,
              "42    ");
      add_row(64'd42, 5'd10, 6'd6, 6'd0, 7'd64, SIGN_PLUS, F_SIGNED | F_ZPAD, "+00042");
      add_row(64'd7, 5'd10, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_SPACE, 6'b0, " 7");
      add_row(64'd7, 5'd10, 6'd0, 6'd0, 7'd64, SIGN_PLUS_ALSO, 6'b0, "+7");
      add_row(64'd1234567, 5'd10, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_GROUP,
              "1_234_567");
      add_row(64'h12345, 5'd16, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_GROUP, "1_2345");
      add_row(64'd1234, 5'd10, 6'd8, 6'd0, 7'd64, itf_pkg::SIGN_NONE, F_ZPAD | F_GROUP,
              "0001_234");
      add_row(64'd42, 5'd10, 6'd0, 6'd5, 7'd64, itf_pkg::SIGN_NONE, 6'b0, "00042");
      add_row(64'd5, 5'd0, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, 6'b0, "101");
      add_row(64'd255, 5'd31, 6'd0, 6'd0, 7'd64, itf_pkg::SIGN_NONE, 6'b0, "ff");
      add_row(64'd42, 5'd10, 6'd0, 6'd63, 7'd2, SIGN_PLUS, F_SIGNED, "");
      add_row(64'd0, 5'd10, 6'd63, 6'd0, 7'd0, itf_pkg::SIGN_NONE, 6'b0, "");
      add_row(64'h8000_0000_0000_0000, 5'd2, 6'd63, 6'd63, 7'd127, itf_pkg::SIGN_SPACE,
              F_SIGNED | F_LEFT | F_GROUP, "");
      add_row(64'd0 - 64'd5, 5'd10, 6'd4, 6'd0, 7'd1, itf_pkg::SIGN_NONE, F_SIGNED,
              "  -5");

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      total_nums = number_table.size() + RANDOM_NUMS;
      for (int n = 0; n < total_nums; n++) begin
         if (n < number_table.size()) begin
            row = number_table[n];
         end else begin
            row.num  = random_number();
            row.text = "";
         end
         // Bursts pause every third stretch of forty numbers and stop near the end.
         bursts_on = (n < total_nums - QUIET_TAIL) && ((n / 40) % 3 != 2);
         send_number(row);
      end
      req_tvalid <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (pending_chars.size() != 0) begin
         $error("%0d character words never arrived", pending_chars.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
